@@ rtl/core/fqsi_pkg.sv @@
package fqsi_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_INSERT = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_PLACE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [CW-1:0]            count;
    logic                     empty_res;
    status_t                  status;
    logic signed [WORD_W-1:0] data;
  } result_t;

  // Circular slot arithmetic; both operands below DEPTH.
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] base);
    logic [AW-1:0] res;
    if (base == '0) begin
      res = AW'(DEPTH - 1);
    end else begin
      res = base - AW'(1);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/fqsi_ram.sv @@
module fqsi_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = $clog2(DEPTH_P)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW_P-1:0]    wr_addr,
  input  logic [WIDTH_P-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW_P-1:0]    rd_addr,
  output logic [WIDTH_P-1:0] rd_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/fqsi_ctrl.sv @@
module fqsi_ctrl (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  fqsi_pkg::op_t                         cmd_op,
  input  logic signed [fqsi_pkg::WORD_W-1:0]    cmd_word,
  output fqsi_pkg::mem_req_t                    mem_req,
  input  logic [fqsi_pkg::WORD_W-1:0]           mem_rd_data,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output fqsi_pkg::result_t                     res
);

  fqsi_pkg::state_t                      state_r, state_nxt;
  logic [fqsi_pkg::AW-1:0]               head_r, head_nxt;
  logic [fqsi_pkg::CW-1:0]               count_r, count_nxt;
  logic [fqsi_pkg::CW-1:0]               idx_r, idx_nxt;
  fqsi_pkg::op_t                         op_r;
  logic signed [fqsi_pkg::WORD_W-1:0]    word_r;
  logic signed [fqsi_pkg::WORD_W-1:0]    data_r, data_nxt;
  fqsi_pkg::status_t                     status_r, status_nxt;

  logic                          full;
  logic                          empty;
  logic                          rd_less;
  logic                          scan_last;
  logic [fqsi_pkg::AW-1:0]       head_dec;
  logic [fqsi_pkg::AW-1:0]       idx_slot;
  logic [fqsi_pkg::CW-1:0]       idx_inc;

  assign full      = (count_r == fqsi_pkg::CW'(fqsi_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign head_dec  = fqsi_pkg::slot_dec(head_r);
  assign idx_slot  = idx_r[fqsi_pkg::AW-1:0];
  assign idx_inc   = idx_r + fqsi_pkg::CW'(1);
  assign rd_less   = ($signed(mem_rd_data) < word_r);
  assign scan_last = (idx_inc == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fqsi_pkg::S_IDLE: begin
        if (cmd_valid) state_nxt = fqsi_pkg::S_EXEC;
      end
      fqsi_pkg::S_EXEC: begin
        state_nxt = fqsi_pkg::S_RESULT;
        case (op_r)
          fqsi_pkg::OP_POP, fqsi_pkg::OP_PEEK: begin
            if (!empty) state_nxt = fqsi_pkg::S_READ;
          end
          fqsi_pkg::OP_INSERT: begin
            if (!full && !empty) state_nxt = fqsi_pkg::S_SCAN;
          end
          default: ;
        endcase
      end
      fqsi_pkg::S_READ:  state_nxt = fqsi_pkg::S_RESULT;
      fqsi_pkg::S_SCAN: begin
        if (!rd_less) begin
          state_nxt = fqsi_pkg::S_RESULT;
        end else if (scan_last) begin
          state_nxt = fqsi_pkg::S_PLACE;
        end
      end
      fqsi_pkg::S_PLACE:  state_nxt = fqsi_pkg::S_RESULT;
      fqsi_pkg::S_RESULT: begin
        if (res_ready) state_nxt = fqsi_pkg::S_IDLE;
      end
      default: state_nxt = fqsi_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    mem_req    = '0;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    unique case (state_r)
      fqsi_pkg::S_IDLE: cmd_ready = 1'b1;
      fqsi_pkg::S_EXEC: begin
        data_nxt   = '0;
        status_nxt = fqsi_pkg::STAT_OK;
        idx_nxt    = '0;
        case (op_r)
          fqsi_pkg::OP_PUSH: begin
            if (full) begin
              status_nxt = fqsi_pkg::STAT_OVERFLOW;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = fqsi_pkg::slot_add(head_r, count_r[fqsi_pkg::AW-1:0]);
              mem_req.wr_data = word_r;
              count_nxt       = count_r + fqsi_pkg::CW'(1);
            end
          end
          fqsi_pkg::OP_POP, fqsi_pkg::OP_PEEK: begin
            if (empty) begin
              status_nxt = fqsi_pkg::STAT_UNDERFLOW;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = head_r;
            end
          end
          fqsi_pkg::OP_INSERT: begin
            if (full) begin
              status_nxt = fqsi_pkg::STAT_OVERFLOW;
            end else if (empty) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = head_dec;
              mem_req.wr_data = word_r;
              head_nxt        = head_dec;
              count_nxt       = fqsi_pkg::CW'(1);
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = head_r;
            end
          end
          fqsi_pkg::OP_CLEAR: begin
            head_nxt  = '0;
            count_nxt = '0;
          end
          default: ;
        endcase
      end
      fqsi_pkg::S_READ: begin
        data_nxt = mem_rd_data;
        if (op_r == fqsi_pkg::OP_POP) begin
          head_nxt  = fqsi_pkg::slot_add(head_r, fqsi_pkg::AW'(1));
          count_nxt = count_r - fqsi_pkg::CW'(1);
        end
      end
      fqsi_pkg::S_SCAN: begin
        // fetch the following entry while this one is compared
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = fqsi_pkg::slot_add(head_r, idx_inc[fqsi_pkg::AW-1:0]);
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = fqsi_pkg::slot_add(head_dec, idx_slot);
        if (rd_less) begin
          mem_req.wr_data = mem_rd_data;
          idx_nxt         = idx_inc;
        end else begin
          mem_req.wr_data = word_r;
          head_nxt        = head_dec;
          count_nxt       = count_r + fqsi_pkg::CW'(1);
        end
      end
      fqsi_pkg::S_PLACE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = fqsi_pkg::slot_add(head_dec, idx_slot);
        mem_req.wr_data = word_r;
        head_nxt        = head_dec;
        count_nxt       = count_r + fqsi_pkg::CW'(1);
      end
      fqsi_pkg::S_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.data      = data_r;
  assign res.status    = status_r;
  assign res.empty_res = (count_r == '0);
  assign res.count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqsi_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    if (cmd_valid && cmd_ready) begin
      op_r   <= cmd_op;
      word_r <= cmd_word;
    end
  end

endmodule

@@ rtl/core/fifo_queue_with_sorted_insert.sv @@
// Bounded queue of signed words with push, pop, peek, clear and sorted insert.
// Operations are handled one item at a time: a new transfer is taken only after the result of
// the last one has been accepted into the output register. A sorted insert walks the entry
// RAM one slot per cycle past the leading entries that are less than the new value.
// Reset (rst_n low, synchronous) empties the queue.
module fifo_queue_with_sorted_insert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[2:0], value[34:3], zero pad[39:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // data[31:0], status[33:32], empty_res[34], count[39:35]
);

  fqsi_pkg::mem_req_t                  mem_req;
  logic [fqsi_pkg::WORD_W-1:0]         mem_rd_data;
  logic                                res_valid;
  logic                                res_ready;
  fqsi_pkg::result_t                   res;
  fqsi_pkg::result_t                   out_res_r;
  logic                                out_valid_r;

  fqsi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd_op      (fqsi_pkg::op_t'(in_tdata[2:0])),
    .cmd_word    ($signed(in_tdata[34:3])),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  fqsi_ram #(
    .DEPTH_P (fqsi_pkg::DEPTH),
    .WIDTH_P (fqsi_pkg::WORD_W),
    .AW_P    (fqsi_pkg::AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register: take a new result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.count, out_res_r.empty_res, out_res_r.status,
                       out_res_r.data};

endmodule
